// ===== hdl/cldfe_pkg.sv =====
// Package with types and constants shared by the decision-feedback equalizer.
package cldfe_pkg;

  localparam int SMP_W = 16;
  localparam int COEF_W = 24;
  localparam int STEP_W = 16;
  localparam int PROD_W = 41;
  localparam int ACC_W = 48;
  localparam int UPD_W = 58;
  localparam int RS_W = 33;
  localparam logic signed [SMP_W-1:0] ONE_Q12 = 16'sd4096;
  localparam logic signed [COEF_W-1:0] COEF_RESET = 24'sd1049;
  localparam logic [STEP_W-1:0] STEP_RESET = 16'd328;

  // Control handed from the sequencer to every cell.
  typedef struct packed {
    logic shift;   // shift the regressor line by one cell
    logic mac;     // register this cell's product and step-scaled regressor
    logic upd;     // apply this cell's coefficient update
  } cell_ctl_t;

  function automatic logic signed [SMP_W-1:0] trn_val(input logic neg);
    trn_val = neg ? -ONE_Q12 : ONE_Q12;
  endfunction

  function automatic logic signed [SMP_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
    if (v > ACC_W'(32767)) sat16 = 16'sh7fff;
    else if (v < -ACC_W'(32768)) sat16 = -16'sh8000;
    else sat16 = v[SMP_W-1:0];
  endfunction

  // Round to nearest by adding half an LSB, then arithmetic shift by 20.
  function automatic logic signed [ACC_W-1:0] rnd20(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    t = v + (ACC_W'(1) <<< 19);
    rnd20 = t >>> 20;
  endfunction

endpackage

// ===== hdl/cldfe_if.sv =====
// Valid/ready channel interfaces for input and result items.
interface cldfe_in_if;
  logic in_valid;
  logic in_ready;
  logic signed [15:0] in_rx_re;
  logic signed [15:0] in_rx_im;
  logic in_train_re_neg;
  logic in_train_im_neg;
  modport source(output in_valid, in_rx_re, in_rx_im, in_train_re_neg, in_train_im_neg,
                 input in_ready);
  modport sink(input in_valid, in_rx_re, in_rx_im, in_train_re_neg, in_train_im_neg,
               output in_ready);
endinterface

interface cldfe_out_if;
  logic out_valid;
  logic out_ready;
  logic signed [15:0] out_eq_re;
  logic signed [15:0] out_eq_im;
  logic signed [15:0] out_err_re;
  logic signed [15:0] out_err_im;
  logic out_dec_re_neg;
  logic out_dec_im_neg;
  modport source(output out_valid, out_eq_re, out_eq_im, out_err_re, out_err_im,
                 out_dec_re_neg, out_dec_im_neg, input out_ready);
  modport sink(input out_valid, out_eq_re, out_eq_im, out_err_re, out_err_im,
               out_dec_re_neg, out_dec_im_neg, output out_ready);
endinterface

// ===== hdl/cldfe_cell.sv =====
// One tap cell: holds a regressor entry and its coefficient, passes the entry on.
module cldfe_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  cldfe_pkg::cell_ctl_t            ctl,
  input  logic signed [15:0]              rin_re,
  input  logic signed [15:0]              rin_im,
  output logic signed [15:0]              rout_re,
  output logic signed [15:0]              rout_im,
  input  logic signed [15:0]              err_re,
  input  logic signed [15:0]              err_im,
  input  logic [15:0]                     step,
  output logic signed [cldfe_pkg::ACC_W-1:0] pacc_re,
  output logic signed [cldfe_pkg::ACC_W-1:0] pacc_im
);
  import cldfe_pkg::*;

  logic signed [SMP_W-1:0] r_re_r, r_im_r;
  logic signed [COEF_W-1:0] c_re_r, c_im_r;
  logic signed [ACC_W-1:0] p_re_r, p_im_r;
  logic signed [RS_W-1:0] rs_re_r, rs_im_r;
  logic signed [PROD_W-1:0] prod_re, prod_im;
  logic signed [UPD_W-1:0] u_re, u_im;
  logic signed [ACC_W-1:0] ur, ui;
  logic signed [ACC_W-1:0] s_re, s_im;

  // The regressor entry is scaled by the step ahead of time, so the update
  // cycle needs only one multiply by the error.
  always_comb begin
    prod_re = PROD_W'(r_re_r * c_re_r) - PROD_W'(r_im_r * c_im_r);
    prod_im = PROD_W'(r_re_r * c_im_r) + PROD_W'(r_im_r * c_re_r);
    u_re = UPD_W'(rs_re_r * err_re) + UPD_W'(rs_im_r * err_im);
    u_im = UPD_W'(rs_re_r * err_im) - UPD_W'(rs_im_r * err_re);
    ur = ACC_W'((u_re + (UPD_W'(1) <<< 19)) >>> 20);
    ui = ACC_W'((u_im + (UPD_W'(1) <<< 19)) >>> 20);
    s_re = ACC_W'(c_re_r) + ur;
    s_im = ACC_W'(c_im_r) + ui;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_re_r <= '0;
      r_im_r <= '0;
      c_re_r <= COEF_RESET;
      c_im_r <= COEF_RESET;
    end else begin
      if (ctl.shift) begin
        r_re_r <= rin_re;
        r_im_r <= rin_im;
      end
      if (ctl.upd) begin
        if (s_re > ACC_W'(8388607)) c_re_r <= 24'sh7fffff;
        else if (s_re < -ACC_W'(8388608)) c_re_r <= -24'sh800000;
        else c_re_r <= s_re[COEF_W-1:0];
        if (s_im > ACC_W'(8388607)) c_im_r <= 24'sh7fffff;
        else if (s_im < -ACC_W'(8388608)) c_im_r <= -24'sh800000;
        else c_im_r <= s_im[COEF_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mac) begin
      p_re_r <= ACC_W'(prod_re);
      p_im_r <= ACC_W'(prod_im);
      rs_re_r <= RS_W'(r_re_r * $signed({1'b0, step}));
      rs_im_r <= RS_W'(r_im_r * $signed({1'b0, step}));
    end
  end

  assign rout_re = r_re_r;
  assign rout_im = r_im_r;
  assign pacc_re = p_re_r;
  assign pacc_im = p_im_r;
endmodule

// ===== hdl/complex_lms_dfe_trained.sv =====
// Top level of the complex trained LMS decision-feedback equalizer.
// Input channel in_: one received Q3.12 sample and a QPSK training sign pair
// per item. Result channel out_: equalizer output, error and hard decision,
// one result item per input item. cfg_: write enable and data for step_size.
// An item runs through these steps in order: shift the tap row, register every
// cell's product and step-scaled regressor, sum the registered products and form
// the error, then update all coefficients in parallel. The adder over all cell
// products sets the third step. The result is valid after the update step;
// one item is in work at a time, so a new item is taken once the previous
// result is in the output register and that register is free or being read
// in the same cycle. A stalled receiver holds the result; the next item waits
// only until it is taken. Reset clears the sample and training lines, sets every
// coefficient part to 1049 and step_size to 328.
module complex_lms_dfe_trained #(
  parameter int FWD_TAPS_MINUS_ONE = 8,
  parameter int BACK_TAPS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  cldfe_in_if.sink    in_ch,
  cldfe_out_if.source out_ch,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import cldfe_pkg::*;

  localparam int NFWD = FWD_TAPS_MINUS_ONE + 1;
  localparam int NTRN = FWD_TAPS_MINUS_ONE + BACK_TAPS;
  localparam int NCOEF = NFWD + BACK_TAPS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MAC = 2'd1;
  localparam logic [1:0] S_SUM = 2'd2;
  localparam logic [1:0] S_UPD = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [STEP_W-1:0] step_r;
  logic [1:0] trn_r [NTRN+1];
  logic [1:0] cur_r;
  logic signed [SMP_W-1:0] err_re_r, err_im_r;
  logic signed [SMP_W-1:0] y_re_r, y_im_r;
  logic ovalid_r;
  cell_ctl_t ctl;
  logic accept;

  logic signed [SMP_W-1:0] chain_re [NCOEF+1];
  logic signed [SMP_W-1:0] chain_im [NCOEF+1];
  logic signed [ACC_W-1:0] pr [NCOEF];
  logic signed [ACC_W-1:0] pi [NCOEF];
  logic signed [ACC_W-1:0] sum_re, sum_im;
  logic signed [SMP_W-1:0] yr, yi;
  logic [1:0] dsym;
  logic signed [ACC_W-1:0] dre, dim;

  assign in_ch.in_ready = (state_r == S_IDLE) && (!ovalid_r || out_ch.out_ready);
  assign accept = in_ch.in_valid && in_ch.in_ready;

  assign ctl.shift = accept;
  assign ctl.mac = (state_r == S_MAC);
  assign ctl.upd = (state_r == S_UPD);

  always_comb begin
    case (state_r)
      S_IDLE:  state_nxt = accept ? S_MAC : S_IDLE;
      S_MAC:   state_nxt = S_SUM;
      S_SUM:   state_nxt = S_UPD;
      S_UPD:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign chain_re[0] = in_ch.in_rx_re;
  assign chain_im[0] = in_ch.in_rx_im;

  // Feedback taps take the delayed training symbol, not the previous cell.
  genvar g;
  generate
    for (g = 0; g < NCOEF; g++) begin : g_cell
      logic signed [SMP_W-1:0] rin_re, rin_im;
      if (g < NFWD) begin : g_fwd
        assign rin_re = chain_re[g];
        assign rin_im = chain_im[g];
      end else begin : g_back
        assign rin_re = trn_val(trn_r[g-1][0]);
        assign rin_im = trn_val(trn_r[g-1][1]);
      end
      cldfe_cell u_cell (
        .clk(clk), .rst_n(rst_n), .ctl(ctl),
        .rin_re(rin_re), .rin_im(rin_im),
        .rout_re(chain_re[g+1]), .rout_im(chain_im[g+1]),
        .err_re(err_re_r), .err_im(err_im_r), .step(step_r),
        .pacc_re(pr[g]), .pacc_im(pi[g])
      );
    end
  endgenerate

  always_comb begin
    sum_re = '0;
    sum_im = '0;
    for (int j = 0; j < NCOEF; j++) begin
      sum_re = sum_re + pr[j];
      sum_im = sum_im + pi[j];
    end
    yr = sat16(rnd20(sum_re));
    yi = sat16(rnd20(sum_im));
    dsym = (FWD_TAPS_MINUS_ONE == 0) ? cur_r : trn_r[(NFWD > 1) ? NFWD - 2 : 0];
    dre = ACC_W'(trn_val(dsym[0])) - ACC_W'(yr);
    dim = ACC_W'(trn_val(dsym[1])) - ACC_W'(yi);
  end

  // The training line shifts only at the end of the update step, so the cells use the
  // pre-shift symbols during the whole item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r <= STEP_RESET;
      ovalid_r <= 1'b0;
      cur_r <= '0;
      for (int j = 0; j <= NTRN; j++) trn_r[j] <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) step_r <= cfg_wdata;
      if (accept) cur_r <= {in_ch.in_train_im_neg, in_ch.in_train_re_neg};
      if (state_r == S_UPD) begin
        for (int j = NTRN; j > 0; j--) trn_r[j] <= trn_r[j-1];
        trn_r[0] <= cur_r;
      end
      if (state_r == S_UPD) ovalid_r <= 1'b1;
      else if (out_ch.out_ready) ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_SUM) begin
      y_re_r <= yr;
      y_im_r <= yi;
      err_re_r <= sat16(dre);
      err_im_r <= sat16(dim);
    end
  end

  assign out_ch.out_valid = ovalid_r;
  assign out_ch.out_eq_re = y_re_r;
  assign out_ch.out_eq_im = y_im_r;
  assign out_ch.out_err_re = err_re_r;
  assign out_ch.out_err_im = err_im_r;
  assign out_ch.out_dec_re_neg = y_re_r[SMP_W-1];
  assign out_ch.out_dec_im_neg = y_im_r[SMP_W-1];

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_MAC) else $error("accept did not start the sequence");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !accept) else $error("item accepted while busy");
  a_result_after_upd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_UPD |=> ovalid_r) else $error("result not presented");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r && !out_ch.out_ready |=> ovalid_r && $stable(y_re_r))
    else $error("stalled result changed");
endmodule

// ===== test/tb.sv =====
// Testbench for the complex trained LMS decision-feedback equalizer.
`timescale 1ns / 100ps

module tb;
  import cldfe_pkg::*;

  localparam int NF = 9;
  localparam int NT = 12;
  localparam int NC = 13;
  localparam int NB = 4;

  typedef struct packed {
    logic signed [15:0] eq_re;
    logic signed [15:0] eq_im;
    logic signed [15:0] err_re;
    logic signed [15:0] err_im;
    logic dec_re_neg;
    logic dec_im_neg;
  } eq_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  cldfe_in_if in_ch ();
  cldfe_out_if out_ch ();

  complex_lms_dfe_trained u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Equalizer state as predicted.
  logic signed [15:0] smp_re_q [NF];
  logic signed [15:0] smp_im_q [NF];
  logic [1:0] trn_q [NT];
  logic signed [23:0] tap_re [NC];
  logic signed [23:0] tap_im [NC];
  logic [15:0] step_q;

  eq_result_t expected_q [$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit recv_hold = 1'b0;

  function automatic longint sat_w(longint v, int bits);
    longint hi;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
  endfunction

  function automatic longint round20(longint v);
    return (v + (longint'(1) <<< 19)) >>> 20;
  endfunction

  function automatic longint sign_q12(logic neg);
    return neg ? -4096 : 4096;
  endfunction

  task automatic reset_model();
    for (int j = 0; j < NF; j++) begin
      smp_re_q[j] = '0;
      smp_im_q[j] = '0;
    end
    for (int j = 0; j < NT; j++) trn_q[j] = '0;
    for (int j = 0; j < NC; j++) begin
      tap_re[j] = 24'sd1049;
      tap_im[j] = 24'sd1049;
    end
    step_q = 16'd328;
  endtask

  task automatic equalize(input logic signed [15:0] rre, input logic signed [15:0] rim,
                          input logic tre, input logic tim);
    longint rr [NC];
    longint ri [NC];
    longint acc_r, acc_i, yr, yi, er, ei, pr, pi;
    logic [1:0] dsym;
    eq_result_t res;
    acc_r = 0;
    acc_i = 0;
    for (int j = NF - 1; j > 0; j--) begin
      smp_re_q[j] = smp_re_q[j-1];
      smp_im_q[j] = smp_im_q[j-1];
    end
    smp_re_q[0] = rre;
    smp_im_q[0] = rim;
    for (int j = 0; j < NF; j++) begin
      rr[j] = smp_re_q[j];
      ri[j] = smp_im_q[j];
    end
    for (int j = 1; j <= NB; j++) begin
      rr[NF-1+j] = sign_q12(trn_q[NF-2+j][0]);
      ri[NF-1+j] = sign_q12(trn_q[NF-2+j][1]);
    end
    for (int j = 0; j < NC; j++) begin
      acc_r += rr[j] * tap_re[j] - ri[j] * tap_im[j];
      acc_i += rr[j] * tap_im[j] + ri[j] * tap_re[j];
    end
    yr = sat_w(round20(acc_r), 16);
    yi = sat_w(round20(acc_i), 16);
    dsym = trn_q[NF-2];
    er = sat_w(sign_q12(dsym[0]) - yr, 16);
    ei = sat_w(sign_q12(dsym[1]) - yi, 16);
    for (int j = 0; j < NC; j++) begin
      pr = rr[j] * er + ri[j] * ei;
      pi = rr[j] * ei - ri[j] * er;
      tap_re[j] = 24'(sat_w(tap_re[j] + round20(pr * longint'(step_q)), 24));
      tap_im[j] = 24'(sat_w(tap_im[j] + round20(pi * longint'(step_q)), 24));
    end
    for (int j = NT - 1; j > 0; j--) trn_q[j] = trn_q[j-1];
    trn_q[0] = {tim, tre};
    res.eq_re = 16'(yr);
    res.eq_im = 16'(yi);
    res.err_re = 16'(er);
    res.err_im = 16'(ei);
    res.dec_re_neg = yr < 0;
    res.dec_im_neg = yi < 0;
    expected_q.push_back(res);
  endtask

  // Leaves valid high after the item is taken; stop_sending drops it.
  task automatic send_item(input logic [15:0] rre, input logic [15:0] rim,
                           input logic tre, input logic tim);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.in_valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.in_valid <= 1'b1;
    in_ch.in_rx_re <= rre;
    in_ch.in_rx_im <= rim;
    in_ch.in_train_re_neg <= tre;
    in_ch.in_train_im_neg <= tim;
    @(posedge clk);
    while (!in_ch.in_ready) @(posedge clk);
    equalize(rre, rim, tre, tim);
  endtask

  task automatic stop_sending();
    in_ch.in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_step(input logic [15:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    step_q = v;
  endtask

  // Receiver: random stalls, or a long hold when requested.
  always @(posedge clk) begin
    out_ch.out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    eq_result_t got, want;
    if (rst_n && out_ch.out_valid && out_ch.out_ready) begin
      got = '{out_ch.out_eq_re, out_ch.out_eq_im, out_ch.out_err_re, out_ch.out_err_im,
              out_ch.out_dec_re_neg, out_ch.out_dec_im_neg};
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected %h actual %h", $time, want, got);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    logic [15:0] ext [4] = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff};
    for (int i = 0; i < 16; i++)
      send_item(ext[i % 4], ext[(i / 4) % 4], i[0], i[1]);
    // Full-scale input on both the in-phase and quadrature rails.
    for (int i = 0; i < 6; i++) send_item(16'h7fff, 16'h7fff, 1'b1, 1'b1);
    stop_sending();
    drain();
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0)
        send_item(16'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
      else
        send_item(16'($urandom_range(8191) - 4096), 16'($urandom_range(8191) - 4096),
                  1'($urandom), 1'($urandom));
    end
    stop_sending();
  endtask

  task automatic test_step_settings();
    write_step(16'd0);
    test_random(30);
    write_step(16'hffff);
    test_random(30);
    write_step(16'd1);
    test_random(30);
    write_step(16'd4000);
    test_random(40);
  endtask

  task automatic test_backpressure();
    recv_hold = 1'b1;
    fork
      test_random(6);
      begin
        repeat (120) @(posedge clk);
        recv_hold = 1'b0;
      end
    join
    drain();
    test_random(10);
  endtask

  initial begin
    in_ch.in_valid = 1'b0;
    in_ch.in_rx_re = '0;
    in_ch.in_rx_im = '0;
    in_ch.in_train_re_neg = 1'b0;
    in_ch.in_train_im_neg = 1'b0;
    out_ch.out_ready = 1'b0;
    reset_model();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    send_idle_pct = 23;
    recv_idle_pct = 70;
    test_random(120);
    test_step_settings();
    send_idle_pct = 70;
    recv_idle_pct = 23;
    write_step(16'd328);
    test_random(120);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random(100);
    drain();
    if (errors == 0 && expected_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end
endmodule

// ===== files.f =====
hdl/cldfe_pkg.sv
hdl/cldfe_if.sv
hdl/cldfe_cell.sv
hdl/complex_lms_dfe_trained.sv
test/tb.sv
